// ----- hdl/sfd_pkg.sv -----
// shared constants and types for the slip frame decoder with sum16 check
`default_nettype none
package sfd_pkg;

    localparam int SFD_BUF_DEPTH = 64;
    localparam int BYTE_W        = 8;
    localparam int SUM_W         = 16;

    localparam logic [BYTE_W-1:0] END_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] ESC_CODE = 8'hDB;
    localparam logic [BYTE_W-1:0] ESC_END  = 8'hDC;
    localparam logic [BYTE_W-1:0] ESC_ESC  = 8'hDD;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [SUM_W-1:0]  t_sum;

endpackage
`default_nettype wire

// ----- hdl/sfd_in_if.sv -----
// valid/ready channel carrying raw received line bytes
`default_nettype none
interface sfd_in_if
    import sfd_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/sfd_out_if.sv -----
// valid/ready channel carrying decoded payload bytes and frame status
`default_nettype none
interface sfd_out_if
    import sfd_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte payload_byte;
    logic  last_of_frame;
    logic  checksum_error;

    modport source (output valid, output payload_byte, output last_of_frame,
                    output checksum_error, input ready);
    modport sink   (input valid, input payload_byte, input last_of_frame,
                    input checksum_error, output ready);
endinterface
`default_nettype wire

// ----- hdl/sfd_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- hdl/slip_frame_decoder_sum16_check.sv -----
// top level: slip deframer with 16-bit additive checksum check
//
//  channel  dir  payload                                          transfer
//  i_in     in   in_byte[7:0]                                     valid & ready
//  o_out    out  payload_byte[7:0], last_of_frame, checksum_error valid & ready
//
// ordinary bytes, escapes and dropped frames never stall the input
// frame end with n stored bytes: a checksum pass over all n bytes, then the
// compare, then a read and a load state per payload byte (single ram read port)
// i_in.ready is low from a qualifying frame end until the last result is loaded
// output register lets a new byte transfer while the last result waits
// synchronous active-low reset clears control state; frame store is not cleared
`default_nettype none
module slip_frame_decoder_sum16_check
    import sfd_pkg::*;
#(
    parameter int BUF_DEPTH = SFD_BUF_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sfd_in_if.sink    i_in,
    sfd_out_if.source o_out
);
    localparam int AW = $clog2(BUF_DEPTH);
    localparam int FW = $clog2(BUF_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_EMIT_RD,
        S_EMIT_LD,
        S_ERR
    } t_state;

    t_state          r_state;
    logic            r_esc;
    logic [FW-1:0]   r_fill;
    logic [FW-1:0]   r_len;
    logic [FW-1:0]   r_last;
    logic [FW-1:0]   r_idx;
    logic [FW-1:0]   r_didx;
    logic            r_dv;
    t_sum            r_sum;
    t_sum            r_got;
    logic            r_out_valid;
    t_byte           r_out_byte;
    logic            r_out_last;
    logic            r_out_err;

    logic            in_xfer;
    logic            is_end;
    logic            is_esc;
    logic            esc_unknown;
    t_byte           dec_byte;
    logic [FW-1:0]   fill_eff;
    logic            room;
    logic            ram_we;
    logic            ram_re;
    t_byte           ram_rdata;
    logic            out_free;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign is_end   = (i_in.in_byte == END_CODE);
    assign is_esc   = (i_in.in_byte == ESC_CODE);
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        esc_unknown = 1'b0;
        dec_byte    = i_in.in_byte;
        if (r_esc) begin
            if (i_in.in_byte == ESC_ESC) begin
                dec_byte = ESC_CODE;
            end else if (i_in.in_byte == ESC_END) begin
                dec_byte = END_CODE;
            end else begin
                esc_unknown = 1'b1;
            end
        end
    end

    assign fill_eff = esc_unknown ? '0 : r_fill;
    assign room     = (fill_eff < FW'(BUF_DEPTH));
    assign ram_we   = in_xfer && !is_end && !is_esc && room;
    assign ram_re   = ((r_state == S_SUM) && (r_idx < r_len)) || (r_state == S_EMIT_RD);

    sfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (fill_eff[AW-1:0]),
        .i_wdata (dec_byte),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_esc       <= 1'b0;
            r_fill      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_dv   <= ram_re && (r_state == S_SUM);
            r_didx <= r_idx;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (is_end) begin
                            r_esc  <= 1'b0;
                            r_fill <= '0;
                            if (!r_esc && (r_fill > FW'(2))) begin
                                r_len   <= r_fill;
                                r_last  <= r_fill - FW'(3);
                                r_idx   <= '0;
                                r_sum   <= '0;
                                r_state <= S_SUM;
                            end
                        end else if (is_esc) begin
                            r_esc <= 1'b1;
                        end else begin
                            r_esc  <= 1'b0;
                            r_fill <= room ? fill_eff + FW'(1) : '0;
                        end
                    end
                end
                S_SUM: begin
                    if (ram_re) begin
                        r_idx <= r_idx + FW'(1);
                    end
                    if (r_dv) begin
                        if (r_didx <= r_last) begin
                            r_sum <= r_sum + SUM_W'(ram_rdata);
                        end else if (r_didx == r_len - FW'(2)) begin
                            r_got[BYTE_W-1:0] <= ram_rdata;
                        end else begin
                            r_got[SUM_W-1:BYTE_W] <= ram_rdata;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_idx <= '0;
                    if (t_sum'(~r_sum + SUM_W'(1)) == r_got) begin
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_state <= S_ERR;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= ram_rdata;
                        r_out_last  <= (r_idx == r_last);
                        r_out_err   <= 1'b0;
                        r_idx       <= r_idx + FW'(1);
                        r_state     <= (r_idx == r_last) ? S_IDLE : S_EMIT_RD;
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= '0;
                        r_out_last  <= 1'b1;
                        r_out_err   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.payload_byte   = r_out_byte;
    assign o_out.last_of_frame  = r_out_last;
    assign o_out.checksum_error = r_out_err;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(BUF_DEPTH))
        else $error("fill count beyond buffer depth");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_last && (r_out_byte == '0)))
        else $error("error result not a lone zero result");

    a_esc_end_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && is_end && r_esc) |=> (i_in.ready && (r_fill == '0) && !r_esc))
        else $error("escaped frame end did not drop the frame");

    a_esc_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && is_esc) |=> (r_esc && $stable(r_fill)))
        else $error("escape byte not held as pending");

    a_busy_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !ram_we)
        else $error("frame store written during readout");
endmodule
`default_nettype wire
